@@ rtl/core/picmp_pkg.sv @@
// shared types and constants of the pi controller with measured period
package picmp_pkg;

  // field and datapath widths fixed by the item format
  localparam int DATA_W     = 16;  // setpoint, measured
  localparam int ERR_W      = 17;  // setpoint - measured
  localparam int OP_W       = 2;
  localparam int GAIN_W     = 16;
  localparam int FADE_W     = 16;
  localparam int TC_W       = 24;
  localparam int DRIVE_W    = 32;
  localparam int MUL_W      = 32;  // shared multiplier operand width
  localparam int PROD_W     = 2 * MUL_W;
  localparam int OPND_W     = 64;  // container for sum magnitude and elapsed product
  localparam int ACC_W      = 128; // full I-term numerator
  localparam int FRAC_SHIFT = 23;  // Q8.8 * Q1.15 scaling
  localparam int PM_W       = 24;  // |P| after the shift
  localparam int QUOT_W     = 34;  // quotient bits worked out by the divider
  localparam int SPLIT      = FRAC_SHIFT + QUOT_W;
  localparam int FIN_W      = 37;  // width of the final P + I sum
  localparam int APB_W      = 32;
  localparam int ADDR_W     = 4;

  // any I term at or above this saturates the drive anyway
  localparam logic [QUOT_W:0] I_CAP = {1'b1, {QUOT_W{1'b0}}};

  // item kinds carried in tuser
  localparam logic [OP_W-1:0] OP_STEP  = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_GAIN  = 2'd0;
  localparam logic [1:0] REG_TC    = 2'd1;
  localparam logic [1:0] REG_IFADE = 2'd2;
  localparam logic [1:0] REG_PFADE = 2'd3;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain;
    logic [TC_W-1:0]          time_constant;
    logic [FADE_W-1:0]        integral_fade;
    logic [FADE_W-1:0]        proportional_fade;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [TC_W-1:0]   rem0;     // upper dividend part, already below divisor
    logic [QUOT_W-1:0] bits;     // lower dividend bits, msb first
    logic [TC_W-1:0]   divisor;
  } div_req_t;

endpackage

@@ rtl/core/picmp_regs.sv @@
// apb register file holding gain, time constant and fades
module picmp_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [picmp_pkg::ADDR_W-1:0]   paddr,
  input  logic [picmp_pkg::APB_W-1:0]    pwdata,
  output logic [picmp_pkg::APB_W-1:0]    prdata,
  output picmp_pkg::cfg_t                cfg
);

  logic       wr;
  logic [1:0] idx;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain              <= 16'sd256;
      cfg.time_constant     <= 24'd1000000;
      cfg.integral_fade     <= 16'd32768;
      cfg.proportional_fade <= 16'd32768;
    end else if (wr) begin
      case (idx)
        picmp_pkg::REG_GAIN:  cfg.gain <= pwdata[picmp_pkg::GAIN_W-1:0];
        picmp_pkg::REG_TC:    cfg.time_constant <= pwdata[picmp_pkg::TC_W-1:0];
        picmp_pkg::REG_IFADE: cfg.integral_fade <= pwdata[picmp_pkg::FADE_W-1:0];
        picmp_pkg::REG_PFADE: cfg.proportional_fade <= pwdata[picmp_pkg::FADE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      picmp_pkg::REG_GAIN:  prdata = picmp_pkg::APB_W'(cfg.gain);
      picmp_pkg::REG_TC:    prdata = picmp_pkg::APB_W'(cfg.time_constant);
      picmp_pkg::REG_IFADE: prdata = picmp_pkg::APB_W'(cfg.integral_fade);
      picmp_pkg::REG_PFADE: prdata = picmp_pkg::APB_W'(cfg.proportional_fade);
      default:              prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/picmp_mul.sv @@
// shared 32 x 32 unsigned multiplier with registered product
module picmp_mul (
  input  logic                            clk,
  input  logic [picmp_pkg::MUL_W-1:0]     a,
  input  logic [picmp_pkg::MUL_W-1:0]     b,
  output logic [picmp_pkg::PROD_W-1:0]    p
);

  always_ff @(posedge clk) begin
    p <= picmp_pkg::PROD_W'(a) * picmp_pkg::PROD_W'(b);
  end

endmodule

@@ rtl/core/picmp_div.sv @@
// serial restoring divider, one quotient bit per cycle
module picmp_div (
  input  logic                             clk,
  input  logic                             rst,
  input  picmp_pkg::div_req_t              req,
  output logic                             done,
  output logic [picmp_pkg::QUOT_W-1:0]     quot
);

  localparam int CNT_W = $clog2(picmp_pkg::QUOT_W + 1);

  logic [picmp_pkg::TC_W-1:0] rem;
  logic [picmp_pkg::TC_W-1:0] dvs;
  logic [CNT_W-1:0]           cnt;
  logic                       busy;
  logic [picmp_pkg::TC_W:0]   trial;
  logic                       fits;

  assign trial = {rem, quot[picmp_pkg::QUOT_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  // quot doubles as the dividend shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.rem0;
      quot <= req.bits;
      dvs  <= req.divisor;
    end else if (busy) begin
      rem  <= fits ? picmp_pkg::TC_W'(trial - {1'b0, dvs}) : trial[picmp_pkg::TC_W-1:0];
      quot <= {quot[picmp_pkg::QUOT_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(picmp_pkg::QUOT_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

@@ rtl/core/pi_controller_measured_period_top.sv @@
// top level of the pi controller with measured sample period
//
//  channel   dir  signals                                  transfer when
//  --------  ---  ---------------------------------------  -----------------------
//  s_*       in   s_tvalid s_tready s_tdata s_tuser        s_tvalid && s_tready
//  m_*       out  m_tvalid m_tready m_tdata                m_tvalid && m_tready
//  apb       in   psel penable pwrite paddr pwdata prdata  psel && penable && pwrite
//
//  tick, clear and unused kinds are taken while idle and give no result
//  a step runs through the sum update, the preparation, eight passes through the shared
//  multiplier, the overflow check, the serial divider (34 shifts, then done) and the
//  final state before m_tvalid rises; the next transfer can follow once the sequencer
//  is idle again; steps whose integral term saturates skip the divider
//  s_tready is high only while the sequencer is idle
//  a finished result waits in the output register; a following step stalls in its
//  last cycle only if that register is still full
//  rst is synchronous, active high; it loads register defaults and clears the sum
module pi_controller_measured_period_top #(
  parameter int SUM_WIDTH  = 40,
  parameter int TICK_WIDTH = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  // input item
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [31:0]                        s_tdata,  // [15:0] setpoint, [31:16] measured
  input  logic [picmp_pkg::OP_W-1:0]         s_tuser,  // [1:0] op
  // result item
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [picmp_pkg::DRIVE_W-1:0]      m_tdata,  // [31:0] drive
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [picmp_pkg::ADDR_W-1:0]       paddr,
  input  logic [picmp_pkg::APB_W-1:0]        pwdata,
  output logic [picmp_pkg::APB_W-1:0]        prdata,
  output logic                               pready
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SUM  = 8'b0000_0010,
    ST_PREP = 8'b0000_0100,
    ST_MUL  = 8'b0000_1000,
    ST_ACC  = 8'b0001_0000,
    ST_CHK  = 8'b0010_0000,
    ST_DIV  = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_t;

  state_t state;

  picmp_pkg::cfg_t     cfg;
  picmp_pkg::div_req_t div_req;
  logic                div_done;
  logic [picmp_pkg::QUOT_W-1:0] div_quot;

  // controller state
  logic signed [SUM_WIDTH-1:0]  integral_sum;
  logic [TICK_WIDTH-1:0]        elapsed_ticks;
  logic                         first_step;

  // per-step working registers
  logic signed [picmp_pkg::ERR_W-1:0] err;
  logic [TICK_WIDTH-1:0]              elapsed;
  logic [picmp_pkg::GAIN_W-1:0]       gm;
  logic                               gneg;
  logic [picmp_pkg::DATA_W-1:0]       emag;
  logic                               eneg;
  logic [picmp_pkg::OPND_W-1:0]       smag;
  logic                               sneg;
  logic [picmp_pkg::TC_W-1:0]         tc_eff;
  logic [2:0]                         step;
  logic [picmp_pkg::MUL_W-1:0]        fac;
  logic [picmp_pkg::PM_W-1:0]         pm;
  logic [picmp_pkg::OPND_W-1:0]       bprod;
  logic [picmp_pkg::ACC_W-1:0]        acc;
  logic [picmp_pkg::QUOT_W:0]         im;

  logic [picmp_pkg::MUL_W-1:0]  mul_a;
  logic [picmp_pkg::MUL_W-1:0]  mul_b;
  logic [picmp_pkg::PROD_W-1:0] mul_p;

  logic                   accept;
  logic [SUM_WIDTH:0]     sum_ext;
  logic [SUM_WIDTH-1:0]   sum_mag;
  logic                   ovf;
  logic signed [picmp_pkg::FIN_W-1:0] p_s;
  logic signed [picmp_pkg::FIN_W-1:0] i_s;
  logic signed [picmp_pkg::FIN_W-1:0] d_s;
  logic [picmp_pkg::DRIVE_W-1:0]      drive;
  logic                   out_free;

  assign pready   = 1'b1;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  picmp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // operand selection for the shared multiplier
  //   0: |gain| * pfade      1: that * |err|         -> P term
  //   2: |gain| * ifade      3: that * elapsed
  //   4..7: 64 x 64 product with |sum| as four 32-bit partials
  always_comb begin
    case (step)
      3'd0: begin
        mul_a = picmp_pkg::MUL_W'(gm);
        mul_b = picmp_pkg::MUL_W'(cfg.proportional_fade);
      end
      3'd1: begin
        mul_a = fac;
        mul_b = picmp_pkg::MUL_W'(emag);
      end
      3'd2: begin
        mul_a = picmp_pkg::MUL_W'(gm);
        mul_b = picmp_pkg::MUL_W'(cfg.integral_fade);
      end
      3'd3: begin
        mul_a = fac;
        mul_b = picmp_pkg::MUL_W'(elapsed);
      end
      3'd4: begin
        mul_a = bprod[31:0];
        mul_b = smag[31:0];
      end
      3'd5: begin
        mul_a = bprod[31:0];
        mul_b = smag[63:32];
      end
      3'd6: begin
        mul_a = bprod[63:32];
        mul_b = smag[31:0];
      end
      3'd7: begin
        mul_a = bprod[63:32];
        mul_b = smag[63:32];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  picmp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // saturating integral update
  assign sum_ext = {integral_sum[SUM_WIDTH-1], integral_sum} + (SUM_WIDTH + 1)'(err);
  assign sum_mag = integral_sum[SUM_WIDTH-1] ? (~integral_sum + SUM_WIDTH'(1))
                                             : integral_sum;

  // quotient of numerator >> 23 by tc would not fit the divider: I saturates
  assign ovf = (|acc[picmp_pkg::ACC_W-1:picmp_pkg::SPLIT + picmp_pkg::TC_W])
            || (acc[picmp_pkg::SPLIT + picmp_pkg::TC_W - 1:picmp_pkg::SPLIT] >= tc_eff);

  always_comb begin
    div_req.start   = (state == ST_CHK) && !ovf;
    div_req.rem0    = acc[picmp_pkg::SPLIT + picmp_pkg::TC_W - 1:picmp_pkg::SPLIT];
    div_req.bits    = acc[picmp_pkg::SPLIT-1:picmp_pkg::FRAC_SHIFT];
    div_req.divisor = tc_eff;
  end

  picmp_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  // signed P + I and 32-bit saturation
  always_comb begin
    p_s = (eneg ^ gneg) ? -picmp_pkg::FIN_W'(pm) : picmp_pkg::FIN_W'(pm);
    i_s = (sneg ^ gneg) ? -picmp_pkg::FIN_W'(im) : picmp_pkg::FIN_W'(im);
    d_s = p_s + i_s;
    if (d_s[picmp_pkg::FIN_W-1:picmp_pkg::DRIVE_W-1] == '0 ||
        d_s[picmp_pkg::FIN_W-1:picmp_pkg::DRIVE_W-1] == '1) begin
      drive = d_s[picmp_pkg::DRIVE_W-1:0];
    end else begin
      drive = d_s[picmp_pkg::FIN_W-1] ? {1'b1, {(picmp_pkg::DRIVE_W-1){1'b0}}}
                                      : {1'b0, {(picmp_pkg::DRIVE_W-1){1'b1}}};
    end
  end

  // sequencer and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      integral_sum  <= '0;
      elapsed_ticks <= '0;
      first_step    <= 1'b1;
      step          <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      // in ST_FIN a free output register is refilled below
      if (m_tvalid && m_tready && state != ST_FIN) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (s_tuser)
              picmp_pkg::OP_STEP: begin
                first_step    <= 1'b0;
                elapsed_ticks <= '0;
                state         <= ST_SUM;
              end
              picmp_pkg::OP_CLEAR: begin
                integral_sum <= '0;
              end
              picmp_pkg::OP_TICK: begin
                if (elapsed_ticks != '1) begin
                  elapsed_ticks <= elapsed_ticks + TICK_WIDTH'(1);
                end
              end
              default: ;
            endcase
          end
        end
        ST_SUM: begin
          // overflow when the two top bits of the widened sum differ
          if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
            integral_sum <= sum_ext[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                               : {1'b0, {(SUM_WIDTH-1){1'b1}}};
          end else begin
            integral_sum <= sum_ext[SUM_WIDTH-1:0];
          end
          state <= ST_PREP;
        end
        ST_PREP: begin
          step  <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          step <= step + 3'd1;
          state <= (step == 3'd7) ? ST_CHK : ST_MUL;
        end
        ST_CHK: begin
          state <= ovf ? ST_FIN : ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      err     <= picmp_pkg::ERR_W'($signed(s_tdata[15:0]))
               - picmp_pkg::ERR_W'($signed(s_tdata[31:16]));
      elapsed <= first_step ? '0 : elapsed_ticks;
    end
    if (state == ST_SUM) begin
      gm   <= cfg.gain[picmp_pkg::GAIN_W-1] ? (~cfg.gain + picmp_pkg::GAIN_W'(1)) : cfg.gain;
      gneg <= cfg.gain[picmp_pkg::GAIN_W-1];
      emag <= picmp_pkg::DATA_W'(err[picmp_pkg::ERR_W-1] ? -err : err);
      eneg <= err[picmp_pkg::ERR_W-1];
    end
    if (state == ST_PREP) begin
      // integral_sum holds the updated sum here
      smag   <= picmp_pkg::OPND_W'(sum_mag);
      sneg   <= integral_sum[SUM_WIDTH-1];
      tc_eff <= (cfg.time_constant == '0) ? picmp_pkg::TC_W'(1) : cfg.time_constant;
    end
    if (state == ST_ACC) begin
      case (step)
        3'd0, 3'd2: fac   <= mul_p[picmp_pkg::MUL_W-1:0];
        3'd1:       pm    <= mul_p[picmp_pkg::FRAC_SHIFT + picmp_pkg::PM_W - 1:
                                   picmp_pkg::FRAC_SHIFT];
        3'd3:       bprod <= mul_p;
        3'd4:       acc   <= picmp_pkg::ACC_W'(mul_p);
        3'd5, 3'd6: acc   <= acc + (picmp_pkg::ACC_W'(mul_p) << 32);
        3'd7:       acc   <= acc + (picmp_pkg::ACC_W'(mul_p) << 64);
        default: ;
      endcase
    end
    if (state == ST_CHK && ovf) begin
      im <= picmp_pkg::I_CAP;
    end
    if (state == ST_DIV && div_done) begin
      im <= {1'b0, div_quot};
    end
    if (state == ST_FIN && out_free) begin
      m_tdata <= drive;
    end
  end

endmodule

@@ sim/testbench.sv @@
// self-checking testbench for the pi controller with measured sample period
`timescale 1ns / 1ps

module testbench;

  localparam int     SUM_W        = 40;
  localparam int     TICK_W       = 24;
  localparam int     CLK_NS       = 4;
  // idle time after the last drive, which leaves the block time to drain
  localparam int     SETTLE       = 100;
  localparam int     LIMIT_CYCLES = 2_000_000;
  localparam longint DRV_MAX      = 2147483647;
  localparam longint DRV_MIN      = -DRV_MAX - 1;

  // the fourth kind carries no meaning and must be ignored by the block
  localparam logic [picmp_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  logic                              clk;
  logic                              rst      = 1'b1;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [31:0]                       s_tdata  = '0;  // [15:0] setpoint, [31:16] measured
  logic [picmp_pkg::OP_W-1:0]        s_tuser  = '0;  // [1:0] op
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [picmp_pkg::DRIVE_W-1:0]     m_tdata;        // [31:0] drive
  logic                              psel     = 1'b0;
  logic                              penable  = 1'b0;
  logic                              pwrite   = 1'b0;
  logic [picmp_pkg::ADDR_W-1:0]      paddr    = '0;
  logic [picmp_pkg::APB_W-1:0]       pwdata   = '0;
  logic [picmp_pkg::APB_W-1:0]       prdata;
  logic                              pready;

  // when set neither side inserts idle cycles
  bit calm = 1'b0;

  // predictor of the controller plus the queue of drives still to come
  class drive_scoreboard;
    logic signed [picmp_pkg::GAIN_W-1:0] gain;
    logic [picmp_pkg::TC_W-1:0]          tc;
    logic [picmp_pkg::FADE_W-1:0]        ifade;
    logic [picmp_pkg::FADE_W-1:0]        pfade;
    logic signed [SUM_W-1:0]             isum;
    logic [TICK_W-1:0]                   ticks;
    bit                                  awaiting_first;
    logic [picmp_pkg::DRIVE_W-1:0]       pending_drive[$];
    int                                  errors;

    function new();
      gain           = 16'sd256;
      tc             = 24'd1000000;
      ifade          = 16'd32768;
      pfade          = 16'd32768;
      isum           = '0;
      ticks          = '0;
      awaiting_first = 1'b1;
      errors         = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        picmp_pkg::REG_GAIN:  gain  = val[picmp_pkg::GAIN_W-1:0];
        picmp_pkg::REG_TC:    tc    = val[picmp_pkg::TC_W-1:0];
        picmp_pkg::REG_IFADE: ifade = val[picmp_pkg::FADE_W-1:0];
        picmp_pkg::REG_PFADE: pfade = val[picmp_pkg::FADE_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(logic [picmp_pkg::OP_W-1:0] op, logic signed [15:0] sp,
                            logic signed [15:0] ms);
      logic [TICK_W-1:0] el;
      longint            err, acc, smax, smin, p, ival, drv;
      longint unsigned   gm, emag, smag, pm;
      logic [127:0]      a, b, num, den, quo;
      bit                gneg;
      case (op)
        picmp_pkg::OP_TICK: begin
          if (ticks != '1) ticks = ticks + 1'b1;
        end
        picmp_pkg::OP_CLEAR: begin
          isum = '0;
        end
        picmp_pkg::OP_STEP: begin
          el             = awaiting_first ? '0 : ticks;
          awaiting_first = 1'b0;
          ticks          = '0;

          // saturating integral sum
          err  = longint'(sp) - longint'(ms);
          smax = (longint'(1) <<< (SUM_W - 1)) - 1;
          smin = -smax - 1;
          acc  = longint'(isum) + err;
          if (acc > smax) acc = smax;
          else if (acc < smin) acc = smin;
          isum = acc[SUM_W-1:0];

          gneg = gain < 0;
          gm   = gneg ? -longint'(gain) : longint'(gain);
          emag = err < 0 ? -err : err;
          smag = acc < 0 ? -acc : acc;

          pm = (gm * pfade * emag) >> picmp_pkg::FRAC_SHIFT;
          p  = (gneg != (err < 0)) ? -longint'(pm) : longint'(pm);

          // integral term on the exact product, truncated, magnitude capped at 2^62
          a   = gm * ifade * el;
          b   = smag;
          num = a * b;
          den = (tc == 0) ? 128'd1 : 128'(tc);
          den = den << picmp_pkg::FRAC_SHIFT;
          quo = num / den;
          if (quo > (128'd1 << 62)) quo = 128'd1 << 62;
          ival = (gneg != (acc < 0)) ? -longint'(quo[63:0]) : longint'(quo[63:0]);

          drv = p + ival;
          if (drv > DRV_MAX) drv = DRV_MAX;
          if (drv < DRV_MIN) drv = DRV_MIN;
          pending_drive.push_back(drv[picmp_pkg::DRIVE_W-1:0]);
        end
        default: ;
      endcase
    endfunction

    function void check_drive(logic [picmp_pkg::DRIVE_W-1:0] got);
      logic [picmp_pkg::DRIVE_W-1:0] want;
      if (pending_drive.size() == 0) begin
        $display("%0t: unexpected drive, expected none, actual %0d", $time, $signed(got));
        errors++;
      end else begin
        want = pending_drive.pop_front();
        if (got !== want) begin
          $display("%0t: drive mismatch, expected %0d, actual %0d",
                   $time, $signed(want), $signed(got));
          errors++;
        end
      end
    endfunction
  endclass

  drive_scoreboard sb;

  pi_controller_measured_period_top #(
    .SUM_WIDTH (SUM_W),
    .TICK_WIDTH(TICK_W)
  ) dut (.*);

  initial begin
    clk = 1'b0;
    forever #(CLK_NS / 2) clk = ~clk;
  end

  // both handshakes are observed on the values held just before the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_item(s_tuser, s_tdata[15:0], s_tdata[31:16]);
      if (m_tvalid && m_tready) sb.check_drive(m_tdata);
    end
  end

  // result side: a fresh random stall, possibly none, before every transfer
  initial begin : result_sink
    int gap;
    @(posedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  // one input transfer; valid stays high when the next item follows with no gap
  task automatic send_item(logic [picmp_pkg::OP_W-1:0] op, logic [15:0] sp,
                           logic [15:0] ms);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {ms, sp};
    do @(posedge clk); while (!s_tready);
  endtask

  // tick items carry random junk in the unused fields
  task automatic send_ticks(int n);
    repeat (n) send_item(picmp_pkg::OP_TICK, 16'($urandom), 16'($urandom));
  endtask

  // wait until every drive has come back and the block has gone quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending_drive.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // setup cycle, then access cycle; the register takes the value at the access edge
  // psel stays high between writes of one burst, load_config releases the bus
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
  endtask

  task automatic load_config(logic [15:0] g, logic [23:0] tc, logic [15:0] fi,
                             logic [15:0] fp);
    write_reg(picmp_pkg::REG_GAIN, {16'h0, g});
    write_reg(picmp_pkg::REG_TC, {8'h0, tc});
    write_reg(picmp_pkg::REG_IFADE, {16'h0, fi});
    write_reg(picmp_pkg::REG_PFADE, {16'h0, fp});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mix of full range, the extremes and small values that keep the sum moderate
  function automatic logic [15:0] pick_sample();
    int v;
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'h7fff;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      default: begin
        v = $urandom_range(0, 600);
        v = v - 300;
        return v[15:0];
      end
    endcase
  endfunction

  function automatic logic [15:0] pick_fade();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 2))
          0: return 16'h0000;
          1: return 16'h8000;
          default: return 16'hffff;
        endcase
      end
      1: return 16'($urandom);
      default: return 16'($urandom_range(16384, 32768));
    endcase
  endfunction

  task automatic random_config();
    logic [15:0] g;
    logic [23:0] tc;
    int          v;
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 4))
          0: g = 16'h8000;
          1: g = 16'h7fff;
          2: g = 16'h0000;
          3: g = 16'h0100;
          default: g = 16'hff00;
        endcase
      end
      1: g = 16'($urandom);
      default: begin
        v = $urandom_range(0, 2048);
        v = v - 1024;
        g = v[15:0];
      end
    endcase
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 2))
          0: tc = 24'd0;
          1: tc = 24'd1;
          default: tc = 24'hffffff;
        endcase
      end
      1: tc = 24'($urandom);
      default: tc = 24'($urandom_range(1, 5000));
    endcase
    load_config(g, tc, pick_fade(), pick_fade());
  endtask

  // mostly steps between short tick runs, now and then a long run, a clear or an unused item
  task automatic random_items(int n);
    int count;
    int r;
    int len;
    count = 0;
    while (count < n) begin
      if ($urandom_range(0, 63) == 0) calm = !calm;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        send_item(picmp_pkg::OP_STEP, pick_sample(), pick_sample());
        count++;
      end else if (r < 90) begin
        len = ($urandom_range(0, 99) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 3);
        send_ticks(len);
        count += len;
      end else if (r < 95) begin
        send_item(picmp_pkg::OP_CLEAR, 16'($urandom), 16'($urandom));
        count++;
      end else begin
        send_item(OP_UNUSED, 16'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: ticks before the first step must not count
    send_ticks(2);
    send_item(OP_UNUSED, 16'h7fff, 16'h8000);
    send_item(picmp_pkg::OP_STEP, 16'h7fff, 16'h8000);
    send_ticks(3);
    send_item(picmp_pkg::OP_STEP, 16'h8000, 16'h7fff);
    // clear leaves the tick count and first-step flag alone
    send_item(picmp_pkg::OP_CLEAR, 16'hffff, 16'hffff);
    send_item(picmp_pkg::OP_STEP, 16'h0000, 16'h0000);
    send_ticks(1);
    send_item(picmp_pkg::OP_STEP, 16'hffff, 16'h0000);
    // back-to-back steps see zero elapsed time
    send_item(picmp_pkg::OP_STEP, 16'h0000, 16'h0000);
    settle();

    // largest gain, fades above one, shortest time constant: huge i term
    load_config(16'h7fff, 24'd1, 16'hffff, 16'hffff);
    send_item(picmp_pkg::OP_STEP, 16'd100, 16'hff9c);
    send_ticks(4);
    send_item(picmp_pkg::OP_STEP, 16'h7fff, 16'h8000);
    send_item(picmp_pkg::OP_STEP, 16'h8000, 16'h7fff);
    settle();

    // most negative gain, zero time constant, proportional part off
    load_config(16'h8000, 24'd0, 16'h8000, 16'h0000);
    send_ticks(1);
    send_item(picmp_pkg::OP_STEP, 16'd5, 16'd0);
    send_ticks(1);
    send_item(picmp_pkg::OP_STEP, 16'hfff9, 16'd3);
    send_item(picmp_pkg::OP_CLEAR, 16'h0000, 16'h0000);
    send_item(picmp_pkg::OP_STEP, 16'h0000, 16'h0000);
    settle();

    repeat (6) begin
      random_config();
      random_items(220);
      settle();
    end

    if (sb.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_NS);
    $display("testbench failed");
    $finish;
  end

endmodule
